// ===== hdl/ss_pkg.sv =====
// Shared types and constants for the sortable stack.
// Used by every other file of the project; it depends on nothing else.
package ss_pkg;

    typedef enum logic [1:0] {
        OP_PEEK = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_SORT = 2'd3
    } ss_op_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OVER  = 2'd1;
    localparam logic [1:0] STAT_UNDER = 2'd2;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } ss_cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [COUNT_W-1:0]       entry_count;
        logic [1:0]               status;
    } ss_rsp_t;

endpackage

// ===== hdl/ss_ram.sv =====
// Entry memory of the sortable stack: one write port and one read port
// with registered read data. Depends on ss_pkg for the word width.
module ss_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [ss_pkg::WORD_W-1:0]  wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [ss_pkg::WORD_W-1:0]  rdata
);

    logic signed [ss_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ss_ctrl.sv =====
// Sequencer of the sortable stack: decodes each item, drives the entry
// memory and runs the sort passes. Depends on ss_pkg and ss_ram.
module ss_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ss_pkg::ss_cmd_t cmd,
    input  logic            out_free,
    output logic            res_valid,
    output ss_pkg::ss_rsp_t res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POP    = 5'b00010,
        ST_START  = 5'b00100,
        ST_STREAM = 5'b01000,
        ST_LAST   = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    len_reg, len_next;
    logic [CW-1:0]                    rd_idx_reg, rd_idx_next;
    logic [CW-1:0]                    di_reg, di_next;
    logic signed [ss_pkg::WORD_W-1:0] top_reg, top_next;
    logic signed [ss_pkg::WORD_W-1:0] carry_reg, carry_next;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic signed [ss_pkg::WORD_W-1:0] mem_wdata;
    logic [AW-1:0]                    mem_raddr;
    logic signed [ss_pkg::WORD_W-1:0] rd_data;

    logic                             accept;
    logic [1:0]                       status;
    logic [CW-1:0]                    count_dec;
    logic [CW-1:0]                    count_dec2;
    logic [CW-1:0]                    len_dec;
    logic [CW-1:0]                    di_dec;

    ss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    assign count_dec  = count_reg - CW'(1);
    assign count_dec2 = count_reg - CW'(2);
    assign len_dec    = len_reg - CW'(1);
    assign di_dec     = di_reg - CW'(1);

    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = cmd_valid && cmd_ready;

    // A sort pass streams entries bottom to top, carrying the smallest value
    // seen so far and writing the larger one back one slot below the read.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        di_next     = di_reg;
        top_next    = top_reg;
        carry_next  = carry_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        res_valid   = 1'b0;
        status      = ss_pkg::STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.opcode)
                        ss_pkg::OP_PEEK:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == '0)
                            begin
                                status = ss_pkg::STAT_UNDER;
                            end
                        end
                        ss_pkg::OP_PUSH:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status = ss_pkg::STAT_OVER;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = cmd.push_value;
                                top_next   = cmd.push_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ss_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                                status    = ss_pkg::STAT_UNDER;
                            end
                            else
                            begin
                                count_next = count_dec;
                                if (count_reg == CW'(1))
                                begin
                                    res_valid = 1'b1;
                                end
                                else
                                begin
                                    mem_raddr  = count_dec2[AW-1:0];
                                    state_next = ST_POP;
                                end
                            end
                        end
                        ss_pkg::OP_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                len_next   = count_reg;
                                state_next = ST_START;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                top_next   = rd_data;
                res_valid  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_START:
            begin
                mem_raddr   = '0;
                rd_idx_next = CW'(1);
                di_next     = '0;
                state_next  = ST_STREAM;
            end
            ST_STREAM:
            begin
                mem_raddr   = rd_idx_reg[AW-1:0];
                rd_idx_next = rd_idx_reg + CW'(1);
                di_next     = di_reg + CW'(1);
                if (di_reg == '0)
                begin
                    carry_next = rd_data;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = di_dec[AW-1:0];
                    if (rd_data > carry_reg)
                    begin
                        mem_wdata = rd_data;
                    end
                    else
                    begin
                        mem_wdata  = carry_reg;
                        carry_next = rd_data;
                    end
                end
                if (di_reg == len_dec)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                mem_we    = 1'b1;
                mem_waddr = len_dec[AW-1:0];
                mem_wdata = carry_reg;
                // Only the first pass ends at the top slot.
                if (len_reg == count_reg)
                begin
                    top_next = carry_reg;
                end
                len_next = len_dec;
                if (len_reg == CW'(2))
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.top_value   = (count_next == '0) ? '0 : top_next;
        res.entry_count = ss_pkg::COUNT_W'(count_next);
        res.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        rd_idx_reg <= rd_idx_next;
        di_reg     <= di_next;
        top_reg    <= top_next;
        carry_reg  <= carry_next;
    end

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result produced while the output register is occupied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START || state_reg == ST_STREAM || state_reg == ST_LAST)
        |-> (len_reg >= CW'(2) && len_reg <= count_reg))
        else $error("sort pass length out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (count_reg != '0 && $past(count_reg) == count_reg + CW'(1)))
        else $error("pop read without a remaining entry");

    a_count_still: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |=> $stable(count_reg))
        else $error("entry count changed during a sort pass");

endmodule

// ===== hdl/sortable_stack_top.sv =====
// Sortable stack of signed 32-bit words. Peek and push give their result in
// the accepting cycle, as does pop when no entry remains below the popped
// one; else pop goes on to a pop state for the memory read of the new top.
// Sort of n >= 2 entries runs n-1 passes for len = n down to 2, each a start
// state, a stream state per entry and a last state; sort of fewer than two
// entries ends in the accepting cycle. The single read and single write port
// of the entry memory set these sequences. Results sit in an output
// register; an item is taken only while the sequencer is idle and that
// register is empty or being drained. No reset on the entry memory: only
// data read from below the count is used. Depends on ss_pkg, ss_ctrl, ss_ram.
module sortable_stack_top #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ss_pkg::ss_cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ss_pkg::ss_rsp_t rsp
);

    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    ss_pkg::ss_rsp_t rsp_reg;
    logic            out_free;
    logic            res_valid;
    ss_pkg::ss_rsp_t res;

    assign out_free = !rsp_valid_reg || rsp_ready;

    ss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== test/ss_checker.sv =====
// Result checker for the sortable stack: keeps a shadow copy of the stack,
// predicts the result of every accepted item and compares the returned results.
// Depends on ss_pkg.
`timescale 1ns / 100ps

module ss_checker #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  ss_pkg::ss_cmd_t cmd,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  ss_pkg::ss_rsp_t rsp,
    output int              fail_count,
    output int              pending,
    output int              checked,
    output int              full_pushes,
    output int              empty_reads
);

    logic signed [ss_pkg::WORD_W-1:0] shadow_words [DEPTH];
    int                               shadow_fill;
    ss_pkg::ss_rsp_t                  stack_views_q [$];
    int                               fails;
    int                               compared;
    int                               refused;
    int                               starved;

    // Values descend from the bottom to the top, so the top holds the smallest.
    function automatic void sort_shadow();
        int                               i;
        int                               j;
        logic signed [ss_pkg::WORD_W-1:0] key;
        for (i = 1; i < shadow_fill; i++)
        begin
            key = shadow_words[i];
            j = i;
            while (j > 0 && shadow_words[j-1] < key)
            begin
                shadow_words[j] = shadow_words[j-1];
                j--;
            end
            shadow_words[j] = key;
        end
    endfunction

    function automatic ss_pkg::ss_rsp_t apply_stack_op(ss_pkg::ss_cmd_t item);
        ss_pkg::ss_rsp_t view;
        view.status = ss_pkg::STAT_OK;
        case (ss_pkg::ss_op_t'(item.opcode))
            ss_pkg::OP_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    view.status = ss_pkg::STAT_OVER;
                    refused++;
                end
                else
                begin
                    shadow_words[shadow_fill] = item.push_value;
                    shadow_fill++;
                end
            end
            ss_pkg::OP_POP:
            begin
                if (shadow_fill == 0)
                begin
                    view.status = ss_pkg::STAT_UNDER;
                    starved++;
                end
                else
                begin
                    shadow_fill--;
                end
            end
            ss_pkg::OP_SORT:
            begin
                sort_shadow();
            end
            default:
            begin
                if (shadow_fill == 0)
                begin
                    view.status = ss_pkg::STAT_UNDER;
                    starved++;
                end
            end
        endcase
        view.top_value   = (shadow_fill > 0) ? shadow_words[shadow_fill-1] : '0;
        view.entry_count = shadow_fill[ss_pkg::COUNT_W-1:0];
        return view;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill = 0;
            stack_views_q.delete();
            fails    = 0;
            compared = 0;
            refused  = 0;
            starved  = 0;
        end
        else
        begin
            // The result side goes first: a result never belongs to an item
            // taken at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                if (stack_views_q.size() == 0)
                begin
                    $error("result with no item pending: top_value %0d", rsp.top_value);
                    fails++;
                end
                else
                begin
                    ss_pkg::ss_rsp_t want;
                    want = stack_views_q.pop_front();
                    compared++;
                    if (rsp.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, rsp.top_value);
                        fails++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        fails++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fails++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                stack_views_q.push_back(apply_stack_op(cmd));
            end
        end
        fail_count  <= fails;
        pending     <= stack_views_q.size();
        checked     <= compared;
        full_pushes <= refused;
        empty_reads <= starved;
    end

endmodule

// ===== test/tb.sv =====
// Top of the sortable stack testbench: clock, reset, item stimulus with random
// gaps on both sides, a watchdog and the verdict. Depends on ss_pkg,
// sortable_stack_top and ss_checker.
`timescale 1ns / 100ps

module tb;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1500;
    // Covers a full sort plus both sides' longest gaps, with a wide margin.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic            clk;
    logic            rst_n     = 1'b0;
    logic            cmd_valid = 1'b0;
    logic            cmd_ready;
    ss_pkg::ss_cmd_t cmd       = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    ss_pkg::ss_rsp_t rsp;

    int fail_count;
    int pending;
    int checked;
    int full_pushes;
    int empty_reads;
    int op_sent [4] = '{default: 0};
    int idle_cycles = 0;

    sortable_stack_top #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ss_checker #(
        .DEPTH(STACK_DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .full_pushes (full_pushes),
        .empty_reads (empty_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input ss_pkg::ss_op_t op, input logic signed [31:0] value,
                             input bit no_gap);
        int              gap;
        ss_pkg::ss_cmd_t item;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.opcode     = op;
        item.push_value = value;
        cmd       <= item;
        cmd_valid <= 1'b1;
        op_sent[op]++;
        do @(posedge clk); while (!cmd_ready);
    endtask

    // Half full-range words, the rest small values for duplicates and the extremes.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return WORD_MIN + 1;
                    default: return WORD_MAX - 1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        int             n;
        int             roll;
        int             push_w;
        int             pop_w;
        bit             burst;
        ss_pkg::ss_op_t op;

        burst = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack, a single entry, then a full stack with overflow.
        send_item(ss_pkg::OP_PEEK, 0, burst);
        send_item(ss_pkg::OP_POP, 0, burst);
        send_item(ss_pkg::OP_SORT, 0, burst);
        send_item(ss_pkg::OP_PUSH, WORD_MIN, burst);
        send_item(ss_pkg::OP_SORT, 0, burst);
        send_item(ss_pkg::OP_PEEK, -1, burst);
        send_item(ss_pkg::OP_PUSH, WORD_MAX, burst);
        send_item(ss_pkg::OP_PUSH, 0, burst);
        send_item(ss_pkg::OP_PUSH, -1, burst);
        send_item(ss_pkg::OP_SORT, 0, burst);
        for (n = 0; n < STACK_DEPTH - 4; n++)
        begin
            send_item(ss_pkg::OP_PUSH, pick_word(), burst);
        end
        send_item(ss_pkg::OP_PUSH, 32'sh5A5A_5A5A, burst);
        send_item(ss_pkg::OP_SORT, 0, burst);
        send_item(ss_pkg::OP_POP, 0, burst);
        send_item(ss_pkg::OP_PEEK, 0, burst);

        // Segments lean toward filling, draining or neither, so that both the
        // full and the empty stack are reached again and again.
        push_w = 35;
        pop_w  = 30;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_w = 55;
                        pop_w  = 20;
                    end
                    1:
                    begin
                        push_w = 20;
                        pop_w  = 45;
                    end
                    default:
                    begin
                        push_w = 35;
                        pop_w  = 30;
                    end
                endcase
                burst = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < push_w)
                op = ss_pkg::OP_PUSH;
            else if (roll < push_w + pop_w)
                op = ss_pkg::OP_POP;
            else if (roll < push_w + pop_w + 17)
                op = ss_pkg::OP_PEEK;
            else
                op = ss_pkg::OP_SORT;
            send_item(op, pick_word(), burst);
        end
        cmd_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d push, %0d pop, %0d peek, %0d sort), %0d results checked.",
                 op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
                 op_sent[ss_pkg::OP_PUSH], op_sent[ss_pkg::OP_POP],
                 op_sent[ss_pkg::OP_PEEK], op_sent[ss_pkg::OP_SORT], checked);
        $display("Pushes refused on a full stack: %0d, reads of an empty stack: %0d.",
                 full_pushes, empty_reads);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        bit calm;

        calm = 1'b0;
        wait (rst_n);
        forever
        begin
            // Now and then switch between stretches with and without stalls.
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
